// ===== hdl/mcrc_pkg.sv =====
// ----------------------------------------------------------------------------
// mcrc_pkg
// Shared types, constants and the byte-wide CRC-16 update for the frame CRC
// unit.
// ----------------------------------------------------------------------------
package mcrc_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic MODE_GEN   = 1'b0;
  localparam logic MODE_CHECK = 1'b1;
  localparam logic MODE_RESET = MODE_CHECK;

  // register index of the mode register
  localparam logic REG_MODE = 1'b0;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  // one unit of work handed from the front end to the output sequencer
  typedef struct packed {
    logic [7:0]  data;       // echoed frame byte
    logic [15:0] crc;        // CRC to append (generate mode, last byte)
    logic        append;     // emit CRC low and high after the echo
    logic        crc_ok;     // check result on the frame end
    logic        frame_end;  // echo closes the frame (check mode)
  } job_t;

  // fifo status seen by both sides
  typedef struct packed {
    logic full;
    logic valid;
  } fifo_stat_t;

  // reflected CRC-16, one byte at a time
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/mcrc_front.sv =====
// ----------------------------------------------------------------------------
// mcrc_front
// Accepts frame bytes, runs the CRC and the check-mode hold-back, and pushes
// one job per byte into the queue.
// ----------------------------------------------------------------------------
module mcrc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               mode_i,
  input  logic               valid_i,
  input  logic [7:0]         data_i,
  input  logic               last_i,
  output logic               ready_o,
  input  mcrc_pkg::fifo_stat_t stat_i,
  output logic               push_o,
  output mcrc_pkg::job_t     job_o
);

  logic [15:0] crc_q, crc_d;
  logic [7:0]  older_q, older_d;
  logic [7:0]  newer_q, newer_d;
  logic [1:0]  seen_q, seen_d;

  logic [15:0] gen_crc;
  logic [15:0] chk_crc;
  logic [1:0]  seen_inc;
  logic        match;
  logic        is_gen;

  assign ready_o = !stat_i.full;
  assign push_o  = valid_i && !stat_i.full;
  assign is_gen  = (mode_i == mcrc_pkg::MODE_GEN);

  always_comb begin
    gen_crc  = mcrc_pkg::crc_byte(crc_q, data_i);
    // the oldest held byte joins the CRC once two are held
    chk_crc  = (seen_q >= 2'd2) ? mcrc_pkg::crc_byte(crc_q, older_q) : crc_q;
    seen_inc = (seen_q == 2'd3) ? seen_q : seen_q + 2'd1;
    match    = (seen_inc == 2'd3) && (newer_q == chk_crc[7:0]) &&
               (data_i == chk_crc[15:8]);

    job_o.data      = data_i;
    job_o.crc       = gen_crc;
    job_o.append    = is_gen && last_i;
    job_o.crc_ok    = !is_gen && last_i && match;
    job_o.frame_end = !is_gen && last_i;

    crc_d   = crc_q;
    older_d = older_q;
    newer_d = newer_q;
    seen_d  = seen_q;
    if (push_o) begin
      if (last_i) begin
        crc_d   = mcrc_pkg::CRC_INIT;
        older_d = '0;
        newer_d = '0;
        seen_d  = '0;
      end else if (is_gen) begin
        crc_d = gen_crc;
      end else begin
        crc_d   = chk_crc;
        older_d = newer_q;
        newer_d = data_i;
        seen_d  = seen_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= mcrc_pkg::CRC_INIT;
      older_q <= '0;
      newer_q <= '0;
      seen_q  <= '0;
    end else begin
      crc_q   <= crc_d;
      older_q <= older_d;
      newer_q <= newer_d;
      seen_q  <= seen_d;
    end
  end

endmodule

// ===== hdl/mcrc_fifo.sv =====
// ----------------------------------------------------------------------------
// mcrc_fifo
// Small job queue between the front end and the output sequencer.
// ----------------------------------------------------------------------------
module mcrc_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  mcrc_pkg::job_t       job_i,
  input  logic                 pop_i,
  output mcrc_pkg::job_t       job_o,
  output mcrc_pkg::fifo_stat_t stat_o
);

  localparam int unsigned AW = mcrc_pkg::FIFO_AW;

  mcrc_pkg::job_t mem_q [mcrc_pkg::FIFO_DEPTH];
  logic [AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [AW:0]    count_q, count_d;
  logic           do_pop;

  assign stat_o.full  = (count_q == (AW+1)'(mcrc_pkg::FIFO_DEPTH));
  assign stat_o.valid = (count_q != '0);
  assign job_o        = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && stat_o.valid;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== hdl/mcrc_back.sv =====
// ----------------------------------------------------------------------------
// mcrc_back
// Output sequencer: turns each job into one result, or into echo, CRC low
// and CRC high for a generate-mode frame end, through an output register.
// ----------------------------------------------------------------------------
module mcrc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mcrc_pkg::fifo_stat_t stat_i,
  input  mcrc_pkg::job_t       job_i,
  output logic                 pop_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // out_byte
  output logic [1:0]           m_axis_tuser,   // [0] is_crc, [1] crc_ok
  output logic                 m_axis_tlast    // frame_end
);

  typedef enum logic [1:0] {
    PH_ECHO,
    PH_LOW,
    PH_HIGH
  } phase_e;

  phase_e     phase_q;
  logic       valid_q;
  logic [7:0] data_q;
  logic [1:0] user_q;
  logic       last_q;
  logic       load;

  assign load  = stat_i.valid && (!valid_q || m_axis_tready);
  assign pop_o = load && (!job_i.append || phase_q == PH_HIGH);

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = user_q;
  assign m_axis_tlast  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ECHO;
      valid_q <= 1'b0;
      data_q  <= '0;
      user_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        valid_q <= 1'b0;
      end
      if (load) begin
        valid_q <= 1'b1;
        case (phase_q)
          PH_ECHO: begin
            data_q  <= job_i.data;
            user_q  <= {job_i.crc_ok, 1'b0};
            last_q  <= job_i.frame_end;
            phase_q <= job_i.append ? PH_LOW : PH_ECHO;
          end
          PH_LOW: begin
            data_q  <= job_i.crc[7:0];
            user_q  <= 2'b01;
            last_q  <= 1'b0;
            phase_q <= PH_HIGH;
          end
          PH_HIGH: begin
            data_q  <= job_i.crc[15:8];
            user_q  <= 2'b01;
            last_q  <= 1'b1;
            phase_q <= PH_ECHO;
          end
          default: begin
            phase_q <= PH_ECHO;
          end
        endcase
      end
    end
  end

endmodule

// ===== hdl/modbus_frame_crc_unit_core.sv =====
// ----------------------------------------------------------------------------
// modbus_frame_crc_unit_core
// Modbus CRC-16 unit: appends or checks the trailing CRC of byte frames.
// ----------------------------------------------------------------------------
// Input stream s_axis carries one frame byte per transfer, tlast on the final
// byte. Output stream m_axis carries echoed bytes and appended CRC bytes;
// tuser[0] flags a CRC byte, tuser[1] the check result, tlast the frame end.
// mode (APB, address 0, bit 0): 0 generate and append, 1 check (reset value).
// Write mode only while the unit is idle; the unit does not enforce this.
// A byte is registered into the job queue and then into the output register
// before it is presented on m_axis. Throughput: one byte per cycle while
// the queue is not full and the receiver does not stall; a generate-mode
// final byte occupies the output sequencer for echo, CRC low and CRC high
// in turn, set by the single output register.
// A four-entry job queue decouples the CRC front end from the output; when
// the receiver stalls, the queue fills and s_axis_tready drops.
// Reset clears the CRC to 0xFFFF, empties the queue and selects check mode.
// ----------------------------------------------------------------------------
module modbus_frame_crc_unit_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte
  output logic [1:0]  m_axis_tuser,   // [0] is_crc, [1] crc_ok
  output logic        m_axis_tlast,   // frame_end
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                 mode_q;
  logic                 reg_idx;
  logic                 push;
  logic                 pop;
  mcrc_pkg::job_t       push_job;
  mcrc_pkg::job_t       head_job;
  mcrc_pkg::fifo_stat_t stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign prdata  = (reg_idx == mcrc_pkg::REG_MODE) ? {31'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= mcrc_pkg::MODE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 reg_idx == mcrc_pkg::REG_MODE) begin
      mode_q <= pwdata[0];
    end
  end

  mcrc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .mode_i  (mode_q),
    .valid_i (s_axis_tvalid),
    .data_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .ready_o (s_axis_tready),
    .stat_i  (stat),
    .push_o  (push),
    .job_o   (push_job)
  );

  mcrc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (head_job),
    .stat_o (stat)
  );

  mcrc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stat_i        (stat),
    .job_i         (head_job),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== hdl/mcrc_chk.sv =====
// ----------------------------------------------------------------------------
// mcrc_chk
// Port-level checks for the frame CRC unit, bound to the top level.
// ----------------------------------------------------------------------------
module mcrc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // a passing check is only reported on the frame end
  a_ok_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("crc_ok outside frame end");

  // appended CRC bytes never carry a check result
  a_ok_not_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("crc_ok on a CRC byte");

  // mode reads back what was written
  a_mode_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && !paddr[2] |=>
      prdata[0] == $past(pwdata[0]) || paddr[2])
    else $error("mode read-back mismatch");

endmodule

bind modbus_frame_crc_unit_core mcrc_chk u_mcrc_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .pready        (pready)
);
